>>> src/run_length_input_recorder_defines.svh
// Assertion macros used by the checker file of the run-length input recorder.
`ifndef RUN_LENGTH_INPUT_RECORDER_DEFINES_SVH
`define RUN_LENGTH_INPUT_RECORDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rli_pkg.sv
package rli_pkg;

    localparam int RLI_TABLE_DEPTH = 1024;
    localparam int BTN_W = 10;
    localparam int LEN_W = 16;
    localparam int IDX_W = 10;

    localparam logic [LEN_W-1:0] RUN_CAP = 16'hFFFF;
    localparam logic [BTN_W-1:0] START_MASK_RESET = 10'd8;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REC  = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;

    localparam logic CFG_MODE       = 1'b0;
    localparam logic CFG_START_MASK = 1'b1;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic [BTN_W-1:0] btn;
        logic [LEN_W-1:0] len;
    } t_entry;

    typedef struct packed {
        logic [BTN_W-1:0] held;
        logic [BTN_W-1:0] pressed;
        logic             drives_held;
        logic             drives_pressed;
        logic [IDX_W-1:0] run_index;
    } t_result;

endpackage

>>> src/run_length_input_recorder.sv
// A taken request is registered and evaluated against its table read in S_EVAL, and its
// result is registered at the output; a run that has reached its cap and is continued also
// passes S_EVAL2 (the table entry after it is read first). A new request is taken only in
// S_IDLE, once the table read-modify-write of the last one is done. A start request
// while recording adds a clear of all TABLE_DEPTH entries, one entry a cycle. Reset is
// synchronous and active low; after it the table is cleared, while s_axis_tready stays low.
module run_length_input_recorder import rli_pkg::*; #(
    parameter int TABLE_DEPTH = RLI_TABLE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [BTN_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // buttons_live, entry_index, entry_buttons, entry_frames, zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // held_out, pressed_out, run_index, zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // drives_held, drives_pressed
    output logic [1:0]           m_axis_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;
    logic          res_valid;
    t_result       res;
    logic          out_free;
    logic          r_m_valid;
    t_result       r_m_res;

    assign out_free = !r_m_valid || m_axis_tready;

    rli_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_live      (s_axis_tdata[9:0]),
        .i_eidx      (s_axis_tdata[19:10]),
        .i_ebtn      (s_axis_tdata[29:20]),
        .i_elen      (s_axis_tdata[45:30]),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_out_free  (out_free)
    );

    rli_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_res.run_index, r_m_res.pressed, r_m_res.held};
    assign m_axis_tuser  = {r_m_res.drives_pressed, r_m_res.drives_held};

endmodule

>>> src/rli_table.sv
module rli_table import rli_pkg::*; #(
    parameter int DEPTH = RLI_TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/rli_ctrl.sv
module rli_ctrl import rli_pkg::*; #(
    parameter int DEPTH = RLI_TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [BTN_W-1:0]         i_cfg_data,
    input  logic                     i_s_valid,
    output logic                     o_s_ready,
    input  logic [1:0]               i_kind,
    input  logic [BTN_W-1:0]         i_live,
    input  logic [IDX_W-1:0]         i_eidx,
    input  logic [BTN_W-1:0]         i_ebtn,
    input  logic [LEN_W-1:0]         i_elen,
    output logic                     o_mem_we,
    output logic [$clog2(DEPTH)-1:0] o_mem_waddr,
    output t_entry                   o_mem_wdata,
    output logic [$clog2(DEPTH)-1:0] o_mem_raddr,
    input  t_entry                   i_mem_rdata,
    output logic                     o_res_valid,
    output t_result                  o_res,
    input  logic                     i_out_free
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] FULL_AT = AW'(DEPTH - 2);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_EVAL2 = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [LEN_W-1:0] r_frames, n_frames;
    logic [BTN_W-1:0] r_prev, n_prev;
    logic [1:0]       r_mode;
    logic [BTN_W-1:0] r_mask;
    logic             r_clr_busy, n_clr_busy;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    t_result          r_res, n_res;

    logic [1:0]       r_kind;
    logic [BTN_W-1:0] r_live;
    logic [IDX_W-1:0] r_eidx;
    logic [BTN_W-1:0] r_ebtn;
    logic [LEN_W-1:0] r_elen;

    logic [AW-1:0]    ptr_inc;
    logic             full;
    logic             in_range;
    logic             accept;
    logic             done;
    logic [LEN_W-1:0] play_f;
    logic [BTN_W-1:0] held;
    t_result          res;

    assign ptr_inc  = r_ptr + AW'(1);
    assign full     = (r_ptr >= FULL_AT);
    assign in_range = (17'(r_eidx) < 17'(DEPTH));
    assign accept   = i_s_valid && o_s_ready;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_frames    = r_frames;
        n_prev      = r_prev;
        n_clr_busy  = r_clr_busy;
        n_clr_addr  = r_clr_addr;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_clr_addr;
        o_mem_wdata = '0;
        o_mem_raddr = r_ptr;
        o_s_ready   = 1'b0;
        o_res_valid = 1'b0;
        res         = '0;
        done        = 1'b0;
        play_f      = '0;
        held        = '0;

        // The table clear sweeps one entry per cycle while no request is taken.
        if (r_clr_busy) begin
            o_mem_we = 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                n_clr_busy = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + AW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                o_s_ready = !r_clr_busy;
                if (i_s_valid && !r_clr_busy) begin
                    n_state = S_EVAL;
                    if (i_kind == KIND_START) begin
                        o_mem_raddr = '0;
                    end else if (i_kind == KIND_TICK && r_mode == MODE_PLAY
                                 && r_frames == '0) begin
                        o_mem_raddr = ptr_inc;
                    end
                end
            end
            S_EVAL: begin
                done = 1'b1;
                case (r_kind)
                    KIND_START: begin
                        n_ptr  = '0;
                        n_prev = '0;
                        if (r_mode == MODE_REC) begin
                            n_frames   = '0;
                            n_clr_busy = 1'b1;
                            n_clr_addr = '0;
                        end else begin
                            n_frames = i_mem_rdata.len;
                        end
                    end
                    KIND_WRITE: begin
                        if (in_range) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = AW'(r_eidx);
                            o_mem_wdata = '{btn: r_ebtn, len: r_elen};
                        end
                    end
                    KIND_TICK: begin
                        if (r_mode == MODE_REC) begin
                            if (full) begin
                                res.pressed        = r_mask;
                                res.drives_pressed = 1'b1;
                            end else if (r_live == i_mem_rdata.btn) begin
                                if (i_mem_rdata.len == RUN_CAP) begin
                                    o_mem_raddr = ptr_inc;
                                    n_state     = S_EVAL2;
                                    done        = 1'b0;
                                end else begin
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = r_ptr;
                                    o_mem_wdata = '{btn: i_mem_rdata.btn,
                                                    len: i_mem_rdata.len + LEN_W'(1)};
                                end
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = ptr_inc;
                                o_mem_wdata = '{btn: r_live, len: LEN_W'(1)};
                                n_ptr       = ptr_inc;
                            end
                        end else if (r_mode == MODE_PLAY) begin
                            if (full || r_frames == RUN_CAP || r_live != '0) begin
                                res.pressed        = r_mask;
                                res.drives_pressed = 1'b1;
                            end else begin
                                if (r_frames == '0) begin
                                    n_ptr  = ptr_inc;
                                    play_f = i_mem_rdata.len;
                                end else begin
                                    play_f = r_frames;
                                end
                                n_frames           = play_f - LEN_W'(1);
                                held               = i_mem_rdata.btn;
                                n_prev             = held;
                                res.held           = held;
                                res.pressed        = held & ~r_prev;
                                res.drives_held    = 1'b1;
                                res.drives_pressed = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EVAL2: begin
                done        = 1'b1;
                o_mem_we    = 1'b1;
                o_mem_waddr = ptr_inc;
                o_mem_wdata = '{btn: r_live, len: i_mem_rdata.len + LEN_W'(1)};
                n_ptr       = ptr_inc;
            end
            S_HOLD: begin
                res         = r_res;
                o_res_valid = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (done) begin
            res.run_index = IDX_W'(n_ptr);
            o_res_valid   = 1'b1;
            if (i_out_free) begin
                n_state = S_IDLE;
            end else begin
                n_state = S_HOLD;
                n_res   = res;
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ptr      <= '0;
            r_frames   <= '0;
            r_prev     <= '0;
            r_mode     <= MODE_IDLE;
            r_mask     <= START_MASK_RESET;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_frames   <= n_frames;
            r_prev     <= n_prev;
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MODE) begin
                    r_mode <= i_cfg_data[1:0];
                end else begin
                    r_mask <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_kind <= i_kind;
            r_live <= i_live;
            r_eidx <= i_eidx;
            r_ebtn <= i_ebtn;
            r_elen <= i_elen;
        end
    end

endmodule

>>> src/rli_checker.sv
`include "run_length_input_recorder_defines.svh"

module rli_checker import rli_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic                 i_cfg_index,
    input logic [BTN_W-1:0]     i_cfg_data,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [1:0]           s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]           m_axis_tuser
);

    `RLI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "Stalled result changed.")
    `RLI_ASSERT_IMPL(a_held_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[9:0] == 10'd0, "Held word set without drives_held.")
    `RLI_ASSERT_IMPL(a_pressed_zero, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[19:10] == 10'd0, "Pressed word set without drives_pressed.")
    `RLI_ASSERT_IMPL(a_held_implies_pressed, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[1], "Playback result without pressed word.")

endmodule

bind run_length_input_recorder rli_checker u_rli_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rli_pkg::*;

    localparam int TABLE_DEPTH = RLI_TABLE_DEPTH;
    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int QUIET_CYCLES = TABLE_DEPTH + 16;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int REC_ITEMS = 45;
    localparam int PLAY_ITEMS = 35;
    localparam int PRESSURE_ITEMS = 60;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]       kind;
        logic [BTN_W-1:0] live;
        logic [IDX_W-1:0] idx;
        logic [BTN_W-1:0] btn;
        logic [LEN_W-1:0] frames;
    } t_item;

    typedef struct packed {
        logic             is_cfg;
        logic             cfg_idx;
        logic [BTN_W-1:0] cfg_data;
        logic             chk;
        t_item            it;
        t_result          res;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [BTN_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;

    run_length_input_recorder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic [BTN_W-1:0] run_buttons [TABLE_DEPTH];
    logic [LEN_W-1:0] run_lengths [TABLE_DEPTH];
    int               cur_run;
    logic [LEN_W-1:0] countdown;
    logic [BTN_W-1:0] last_held;
    logic [1:0]       mode_q;
    logic [BTN_W-1:0] mask_q;

    t_result pending_results[$];
    t_row    directed_rows[$];
    int      errors;
    int      cycles;
    int      sent;
    bit      no_gaps;
    bit      hold_req;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[run_length_input_recorder] ERROR");
            $finish;
        end
    end

    function automatic t_result next_run_result(t_item it);
        t_result r;
        r = '0;
        case (it.kind)
            KIND_START: begin
                if (mode_q == MODE_REC) begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        run_buttons[i] = '0;
                        run_lengths[i] = '0;
                    end
                    countdown = '0;
                end else begin
                    countdown = run_lengths[0];
                end
                cur_run = 0;
                last_held = '0;
            end
            KIND_WRITE: begin
                run_buttons[it.idx] = it.btn;
                run_lengths[it.idx] = it.frames;
            end
            KIND_TICK: begin
                if (mode_q == MODE_REC) begin
                    if (cur_run >= TABLE_DEPTH - 2) begin
                        r.pressed = mask_q;
                        r.drives_pressed = 1'b1;
                    end else if (it.live == run_buttons[cur_run]) begin
                        if (run_lengths[cur_run] == RUN_CAP) begin
                            cur_run++;
                            run_buttons[cur_run] = it.live;
                        end
                        run_lengths[cur_run] = run_lengths[cur_run] + 16'd1;
                    end else begin
                        cur_run++;
                        run_buttons[cur_run] = it.live;
                        run_lengths[cur_run] = 16'd1;
                    end
                end else if (mode_q == MODE_PLAY) begin
                    if (cur_run >= TABLE_DEPTH - 2 || countdown == RUN_CAP || it.live != '0) begin
                        r.pressed = mask_q;
                        r.drives_pressed = 1'b1;
                    end else begin
                        if (countdown == '0) begin
                            cur_run++;
                            countdown = run_lengths[cur_run];
                        end
                        r.held = run_buttons[cur_run];
                        r.pressed = (r.held ^ last_held) & r.held;
                        last_held = r.held;
                        countdown = countdown - 16'd1;
                        r.drives_held = 1'b1;
                        r.drives_pressed = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.run_index = cur_run[IDX_W-1:0];
        return r;
    endfunction

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic send_item(t_item it, logic chk, t_result res);
        t_result r;
        int gap;
        r = next_run_result(it);
        pending_results.push_back(chk ? res : r);
        if (sent % 16 == 0) begin
            no_gaps = ($urandom_range(0, 3) == 0);
        end
        sent++;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, it.frames, it.btn, it.idx, it.live};
        s_axis_tuser <= it.kind;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [BTN_W-1:0] data);
        if (idx == CFG_MODE) begin
            mode_q = data[1:0];
        end else begin
            mask_q = data;
        end
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_row(t_item it, logic chk, t_result res);
        directed_rows.push_back({1'b0, 1'b0, {BTN_W{1'b0}}, chk, it, res});
    endtask

    task automatic add_cfg(logic idx, logic [BTN_W-1:0] data);
        directed_rows.push_back({1'b1, idx, data, 1'b0, t_item'('0), t_result'('0)});
    endtask

    function automatic t_item rand_item(logic [1:0] kind);
        t_item it;
        it.kind = kind;
        it.live = BTN_W'($urandom_range(0, 1023));
        it.idx = IDX_W'($urandom_range(0, 1023));
        it.btn = BTN_W'($urandom_range(0, 1023));
        it.frames = LEN_W'($urandom_range(0, 65535));
        return it;
    endfunction

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result tdata %0h tuser %0h", m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_axis_tdata[9:0] !== e.held) begin
                    $error("held_out expected %0h got %0h", e.held, m_axis_tdata[9:0]);
                    errors++;
                end
                if (m_axis_tdata[19:10] !== e.pressed) begin
                    $error("pressed_out expected %0h got %0h", e.pressed, m_axis_tdata[19:10]);
                    errors++;
                end
                if (m_axis_tdata[29:20] !== e.run_index) begin
                    $error("run_index expected %0h got %0h", e.run_index, m_axis_tdata[29:20]);
                    errors++;
                end
                if (m_axis_tuser[0] !== e.drives_held) begin
                    $error("drives_held expected %0h got %0h", e.drives_held, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== e.drives_pressed) begin
                    $error("drives_pressed expected %0h got %0h", e.drives_pressed,
                           m_axis_tuser[1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        t_item it;
        t_row row;
        int pick;
        logic [BTN_W-1:0] live;
        logic [BTN_W-1:0] prev_live;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_MODE;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= KIND_TICK;
        errors = 0;
        sent = 0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            run_buttons[i] = '0;
            run_lengths[i] = '0;
        end
        cur_run = 0;
        countdown = '0;
        last_held = '0;
        mode_q = MODE_IDLE;
        mask_q = START_MASK_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row({KIND_TICK, 10'h3FF, 10'h3FF, 10'h3FF, 16'hFFFF}, 1'b1, '0);
        add_row({KIND_NOP, 10'h3FF, 10'h3FF, 10'h3FF, 16'hFFFF}, 1'b1, '0);
        add_row({KIND_WRITE, 10'h0, 10'h0, 10'h3FF, 16'hFFFF}, 1'b1, '0);
        add_row({KIND_WRITE, 10'h3FF, 10'h3FF, 10'h0, 16'h0}, 1'b1, '0);
        add_row({KIND_START, 10'h0, 10'h0, 10'h0, 16'h0}, 1'b1, '0);
        add_cfg(CFG_MODE, {8'h0, MODE_PLAY});
        add_row({KIND_TICK, 10'h0, 10'h0, 10'h0, 16'h0}, 1'b1,
                {10'h0, 10'd8, 1'b0, 1'b1, 10'd0});
        add_row({KIND_WRITE, 10'h0, 10'h0, 10'h3FF, 16'd2}, 1'b1, '0);
        add_row({KIND_START, 10'h0, 10'h0, 10'h0, 16'h0}, 1'b1, '0);
        add_row({KIND_TICK, 10'h0, 10'h0, 10'h0, 16'h0}, 1'b1,
                {10'h3FF, 10'h3FF, 1'b1, 1'b1, 10'd0});
        add_row({KIND_TICK, 10'h0, 10'h0, 10'h0, 16'h0}, 1'b0, '0);
        add_row({KIND_TICK, 10'h0, 10'h0, 10'h0, 16'h0}, 1'b0, '0);
        add_row({KIND_TICK, 10'h0, 10'h0, 10'h0, 16'h0}, 1'b1,
                {10'h0, 10'd8, 1'b0, 1'b1, 10'd1});
        add_row({KIND_TICK, 10'h1, 10'h0, 10'h0, 16'h0}, 1'b1,
                {10'h0, 10'd8, 1'b0, 1'b1, 10'd1});
        add_cfg(CFG_START_MASK, 10'h3FF);
        add_row({KIND_TICK, 10'h0, 10'h0, 10'h0, 16'h0}, 1'b1,
                {10'h0, 10'h3FF, 1'b0, 1'b1, 10'd1});
        add_cfg(CFG_MODE, {8'h0, MODE_REC});
        add_cfg(CFG_START_MASK, 10'h0);
        add_row({KIND_START, 10'h3FF, 10'h3FF, 10'h3FF, 16'hFFFF}, 1'b1, '0);
        add_row({KIND_TICK, 10'h0, 10'h0, 10'h0, 16'h0}, 1'b1, '0);
        add_row({KIND_TICK, 10'h2AA, 10'h0, 10'h0, 16'h0}, 1'b1,
                {10'h0, 10'h0, 1'b0, 1'b0, 10'd1});
        add_row({KIND_WRITE, 10'h0, 10'h1, 10'h2AA, 16'hFFFF}, 1'b1,
                {10'h0, 10'h0, 1'b0, 1'b0, 10'd1});
        add_row({KIND_TICK, 10'h2AA, 10'h0, 10'h0, 16'h0}, 1'b1,
                {10'h0, 10'h0, 1'b0, 1'b0, 10'd2});
        add_row({KIND_TICK, 10'h155, 10'h0, 10'h0, 16'h0}, 1'b1,
                {10'h0, 10'h0, 1'b0, 1'b0, 10'd3});
        add_row({KIND_NOP, 10'h155, 10'h155, 10'h155, 16'h5555}, 1'b1,
                {10'h0, 10'h0, 1'b0, 1'b0, 10'd3});
        add_cfg(CFG_MODE, 10'h3FF);
        add_row({KIND_TICK, 10'h2AA, 10'h0, 10'h0, 16'h0}, 1'b1,
                {10'h0, 10'h0, 1'b0, 1'b0, 10'd3});

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                settle();
                cfg_write(row.cfg_idx, row.cfg_data);
            end else begin
                send_item(row.it, row.chk, row.res);
            end
        end

        prev_live = '0;
        for (int s = 0; s < 4; s++) begin
            settle();
            cfg_write(CFG_MODE, {8'($urandom_range(0, 255)), MODE_REC});
            cfg_write(CFG_START_MASK, (s == 0) ? 10'h0 : (s == 1) ? 10'h3FF :
                      10'($urandom_range(0, 1023)));
            send_item(rand_item(KIND_START), 1'b0, '0);
            for (int n = 0; n < REC_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    it = rand_item(KIND_TICK);
                    if ($urandom_range(0, 2) != 0) begin
                        it.live = prev_live;
                    end
                end else if (pick < 65) begin
                    it = rand_item(KIND_WRITE);
                    it.idx = cur_run[IDX_W-1:0];
                    it.btn = prev_live;
                    it.frames = $urandom_range(0, 1) ? RUN_CAP : RUN_CAP - 16'd1;
                end else if (pick < 72) begin
                    it = rand_item(KIND_WRITE);
                end else if (pick < 76) begin
                    it = rand_item(KIND_NOP);
                end else if (pick < 78) begin
                    it = rand_item(KIND_START);
                end else begin
                    it = rand_item(KIND_TICK);
                    if (pick < 82) begin
                        it.live = '0;
                    end
                end
                if (it.kind == KIND_TICK) begin
                    prev_live = it.live;
                end
                send_item(it, 1'b0, '0);
            end
            settle();
            cfg_write(CFG_MODE, {8'($urandom_range(0, 255)), MODE_PLAY});
            send_item(rand_item(KIND_START), 1'b0, '0);
            for (int n = 0; n < PLAY_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    it = rand_item(KIND_TICK);
                    it.live = '0;
                end else if (pick < 88) begin
                    it = rand_item(KIND_WRITE);
                    it.idx = 10'(cur_run + $urandom_range(1, 4));
                    it.frames = LEN_W'($urandom_range(0, 3));
                end else if (pick < 92) begin
                    it = rand_item(KIND_START);
                end else if (pick < 95) begin
                    it = rand_item(KIND_NOP);
                end else begin
                    it = rand_item(KIND_TICK);
                end
                send_item(it, 1'b0, '0);
            end
            if (s == 1) begin
                settle();
                cfg_write(CFG_MODE, {8'($urandom_range(0, 255)),
                                     $urandom_range(0, 1) ? MODE_IDLE : MODE_NONE});
                for (int n = 0; n < 15; n++) begin
                    send_item(rand_item(2'($urandom_range(0, 3))), 1'b0, '0);
                end
            end
        end

        settle();
        cfg_write(CFG_MODE, {8'h0, MODE_REC});
        cfg_write(CFG_START_MASK, 10'($urandom_range(0, 1023)));
        hold_req = 1'b1;
        send_item(rand_item(KIND_START), 1'b0, '0);
        prev_live = '0;
        for (int n = 0; n < PRESSURE_ITEMS; n++) begin
            it = rand_item(KIND_TICK);
            do live = BTN_W'($urandom_range(1, 1023)); while (live == prev_live);
            it.live = live;
            prev_live = live;
            send_item(it, 1'b0, '0);
        end
        settle();
        cfg_write(CFG_MODE, {8'h0, MODE_PLAY});
        send_item(rand_item(KIND_START), 1'b0, '0);
        for (int n = 0; n < PRESSURE_ITEMS; n++) begin
            it = rand_item(KIND_TICK);
            it.live = '0;
            send_item(it, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[run_length_input_recorder] OK");
        end else begin
            $display("[run_length_input_recorder] ERROR");
        end
        $finish;
    end

endmodule
